// ===== hw/rtl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8v_pkg
// Types and constants for the streaming utf-8 validator and utf-16 counter.
// ----------------------------------------------------------------------------
package utf8v_pkg;

    localparam int COUNT_WIDTH_DEF = 20;
    localparam int TOTAL_W         = 20;
    localparam int CP_W            = 21;

    localparam logic [7:0] ASCII_LIMIT  = 8'h80;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_CODE   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_CODE   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK   = 8'hF8;
    localparam logic [7:0] LEAD4_CODE   = 8'hF0;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_CODE    = 8'h80;
    localparam logic [7:0] CONT_BITS    = 8'h3F;
    localparam logic [7:0] LEAD2_BITS   = 8'h1F;
    localparam logic [7:0] LEAD3_BITS   = 8'h0F;
    localparam logic [7:0] LEAD4_BITS   = 8'h07;

    localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LOW      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HIGH     = 21'h00DFFF;
    localparam logic [CP_W-1:0] SUPPLEMENTARY = 21'h010000;
    localparam logic [CP_W-1:0] MIN_LEN2      = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3      = 21'h000800;

    localparam logic [1:0] SEQ_NONE = 2'd0;
    localparam logic [1:0] SEQ_TWO  = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic               cp_valid;
        logic [CP_W-1:0]    code_point;
        logic [1:0]         unit_count;
        logic               bad_input;
        logic               string_end;
        logic [TOTAL_W-1:0] total_units;
        logic               total_saturated;
    } out_item_t;

    function automatic logic [CP_W-1:0] min_for_len(input logic [1:0] seq_len);
        logic [CP_W-1:0] m;
        begin
            unique case (seq_len)
                SEQ_TWO:   m = MIN_LEN2;
                SEQ_THREE: m = MIN_LEN3;
                SEQ_FOUR:  m = SUPPLEMENTARY;
                default:   m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

// ===== hw/rtl/utf8_validate_utf16_count.sv =====
// ----------------------------------------------------------------------------
// utf8_validate_utf16_count: one result beat per byte beat, result registered
// one byte per cycle unless stalled; decode state, result reg in one stage
// async reset clears decode state, totals and the result valid
// ----------------------------------------------------------------------------
module utf8_validate_utf16_count #(
    parameter int COUNT_WIDTH = utf8v_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  utf8v_pkg::in_item_t  byte_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output utf8v_pkg::out_item_t res_data
);
    import utf8v_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [1:0]             pending_reg, pending_next;
    logic [1:0]             seq_len_reg, seq_len_next;
    logic [CP_W-1:0]        partial_reg, partial_next;
    logic                   error_reg, error_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic                   sat_reg, sat_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg, res_next;

    logic                   accept;
    logic [7:0]             b;
    logic                   done;
    logic [CP_W-1:0]        cp;
    logic [CP_W-1:0]        shifted;
    logic [1:0]             units;
    logic [COUNT_WIDTH:0]   sum;
    logic [EXT_W-1:0]       total_ext;

    assign byte_stall = res_valid_reg & res_stall;
    assign accept     = byte_valid & ~byte_stall;
    assign res_valid  = res_valid_reg;
    assign res_data   = res_reg;

    always_comb
    begin
        b            = byte_data.in_byte;
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        partial_next = partial_reg;
        error_next   = error_reg;
        total_next   = total_reg;
        sat_next     = sat_reg;
        done         = 1'b0;
        cp           = '0;
        units        = 2'd0;
        shifted      = {partial_reg[CP_W-7:0], b[5:0] & CONT_BITS[5:0]};
        sum          = '0;

        if (!error_reg)
        begin
            if (pending_reg == 2'd0)
            begin
                priority if (b < ASCII_LIMIT)
                begin
                    cp           = {13'd0, b};
                    done         = 1'b1;
                    seq_len_next = SEQ_NONE;
                end
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    seq_len_next = SEQ_TWO;
                    pending_next = 2'd1;
                    partial_next = {13'd0, b & LEAD2_BITS};
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    seq_len_next = SEQ_THREE;
                    pending_next = 2'd2;
                    partial_next = {13'd0, b & LEAD3_BITS};
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    seq_len_next = SEQ_FOUR;
                    pending_next = 2'd3;
                    partial_next = {13'd0, b & LEAD4_BITS};
                end
                else
                begin
                    error_next = 1'b1;
                end
            end
            else if ((b & CONT_MASK) != CONT_CODE)
            begin
                error_next   = 1'b1;
                pending_next = 2'd0;
            end
            else
            begin
                partial_next = shifted;
                pending_next = pending_reg - 2'd1;
                if (pending_reg == 2'd1)
                begin
                    if (shifted < min_for_len(seq_len_reg) || shifted > CP_MAX ||
                        (shifted >= SURR_LOW && shifted <= SURR_HIGH))
                    begin
                        error_next = 1'b1;
                    end
                    else
                    begin
                        done = 1'b1;
                        cp   = shifted;
                    end
                end
            end
        end

        if (done)
        begin
            units = (cp >= SUPPLEMENTARY) ? 2'd2 : 2'd1;
            sum   = {1'b0, total_reg} + (COUNT_WIDTH+1)'(units);
            if (sum[COUNT_WIDTH])
            begin
                total_next = COUNT_MAX;
                sat_next   = 1'b1;
            end
            else
            begin
                total_next = sum[COUNT_WIDTH-1:0];
            end
            partial_next = '0;
            seq_len_next = SEQ_NONE;
        end

        if (byte_data.last && pending_next != 2'd0)
        begin
            error_next = 1'b1;
        end

        total_ext = EXT_W'(total_next);

        res_next.cp_valid        = done;
        res_next.code_point      = cp;
        res_next.unit_count      = units;
        res_next.bad_input       = error_next;
        res_next.string_end      = byte_data.last;
        res_next.total_units     = (byte_data.last && error_next) ? '0
                                                                  : total_ext[TOTAL_W-1:0];
        res_next.total_saturated = sat_next;

        if (byte_data.last)
        begin
            pending_next = 2'd0;
            seq_len_next = SEQ_NONE;
            partial_next = '0;
            error_next   = 1'b0;
            total_next   = '0;
            sat_next     = 1'b0;
        end

        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 2'd0;
            seq_len_reg   <= SEQ_NONE;
            partial_reg   <= '0;
            error_reg     <= 1'b0;
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                pending_reg <= pending_next;
                seq_len_reg <= seq_len_next;
                partial_reg <= partial_next;
                error_reg   <= error_next;
                total_reg   <= total_next;
                sat_reg     <= sat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

endmodule
